FILE: rtl/plist_pkg.sv
// Package: shared types and codes for the positional list engine.
`timescale 1ns / 1ps
package plist_pkg;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_READ   = 2'd2,
    KIND_FIND   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHK,
    S_RD,
    S_WR,
    S_PUT,
    S_DONE
  } state_e;

  localparam int unsigned PosW  = 7;
  localparam int unsigned ValW  = 32;
  localparam int unsigned LenW  = 7;

  typedef struct packed {
    logic load;
    logic rd;
    logic wr;
    logic put;
    logic finish;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  refused;
    logic  empty;
    logic  last;
    logic  match;
  } stat_t;

endpackage

FILE: rtl/plist_ctrl.sv
// Controller: sequences load, memory sweep and result transfer.
`timescale 1ns / 1ps
module plist_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             out_busy_i,
  input  plist_pkg::stat_t stat_i,
  output logic             in_ready_o,
  output plist_pkg::cmd_t  cmd_o
);

  plist_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= plist_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      plist_pkg::S_IDLE: begin
        in_ready_o = !out_busy_i;
        if (in_valid_i && !out_busy_i) begin
          cmd_o.load = 1'b1;
          state_d    = plist_pkg::S_CHK;
        end
      end
      plist_pkg::S_CHK: begin
        priority if (stat_i.refused) begin
          state_d = plist_pkg::S_DONE;
        end else if (stat_i.empty && stat_i.kind == plist_pkg::KIND_INSERT) begin
          state_d = plist_pkg::S_PUT;
        end else if (stat_i.empty) begin
          state_d = plist_pkg::S_DONE;
        end else begin
          state_d = plist_pkg::S_RD;
        end
      end
      plist_pkg::S_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = plist_pkg::S_WR;
      end
      plist_pkg::S_WR: begin
        cmd_o.wr = 1'b1;
        priority if (stat_i.kind == plist_pkg::KIND_INSERT && stat_i.last) begin
          state_d = plist_pkg::S_PUT;
        end else if (stat_i.last ||
                     (stat_i.kind == plist_pkg::KIND_FIND && stat_i.match)) begin
          state_d = plist_pkg::S_DONE;
        end else begin
          state_d = plist_pkg::S_RD;
        end
      end
      plist_pkg::S_PUT: begin
        cmd_o.put = 1'b1;
        state_d   = plist_pkg::S_DONE;
      end
      plist_pkg::S_DONE: begin
        cmd_o.finish = 1'b1;
        state_d      = plist_pkg::S_IDLE;
      end
      default: state_d = plist_pkg::S_IDLE;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == plist_pkg::S_IDLE)
    else $error("ready outside idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd |=> cmd_o.wr)
    else $error("read not followed by write step");

endmodule

FILE: rtl/plist_dp.sv
// Datapath: list memory, count, sweep index and result register.
`timescale 1ns / 1ps
module plist_dp #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  plist_pkg::cmd_t           cmd_i,
  output plist_pkg::stat_t          stat_o,
  input  logic [1:0]                kind_i,
  input  logic [plist_pkg::PosW-1:0] pos_i,
  input  logic [plist_pkg::ValW-1:0] val_i,
  input  logic                      out_ready_i,
  output logic                      out_busy_o,
  output logic                      out_valid_o,
  output logic [1:0]                status_o,
  output logic [plist_pkg::ValW-1:0] value_out_o,
  output logic [plist_pkg::LenW-1:0] found_o,
  output logic [plist_pkg::LenW-1:0] len_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned XW = ((CW > plist_pkg::PosW) ? CW : plist_pkg::PosW) + 1;

  logic [plist_pkg::ValW-1:0] mem [DEPTH];

  plist_pkg::kind_e           kind_q;
  plist_pkg::status_e         st_q, st_d;
  logic [plist_pkg::PosW-1:0] pos_q;
  logic [plist_pkg::ValW-1:0] val_q, rdata_q, vout_q;
  logic [CW-1:0]              idx_q, count_q, idx_init;
  logic [XW-1:0]              found_q;
  logic [XW-1:0]              pos_x, cnt_x, idx_x, pin_x;
  logic [CW-1:0]              rd_idx, wr_idx;
  logic                       wr_en;
  logic [plist_pkg::ValW-1:0] wr_data;
  logic                       out_valid_q;
  logic [1:0]                 o_status_q;
  logic [plist_pkg::ValW-1:0] o_value_q;
  logic [plist_pkg::LenW-1:0] o_found_q, o_len_q;

  always_comb begin
    pos_x = XW'(pos_q);
    cnt_x = XW'(count_q);
    idx_x = XW'(idx_q);
    pin_x = XW'(pos_i);
  end

  always_comb begin
    st_d     = plist_pkg::ST_OK;
    idx_init = '0;
    unique case (plist_pkg::kind_e'(kind_i))
      plist_pkg::KIND_INSERT: begin
        idx_init = count_q;
        priority if (pin_x == '0 || pin_x > cnt_x + XW'(1)) begin
          st_d = plist_pkg::ST_RANGE;
        end else if (cnt_x >= XW'(DEPTH)) begin
          st_d = plist_pkg::ST_FULL;
        end else begin
          st_d = plist_pkg::ST_OK;
        end
      end
      plist_pkg::KIND_REMOVE, plist_pkg::KIND_READ: begin
        idx_init = CW'(pin_x - XW'(1));
        if (pin_x == '0 || pin_x > cnt_x) begin
          st_d = plist_pkg::ST_RANGE;
        end
      end
      plist_pkg::KIND_FIND: begin
        st_d = plist_pkg::ST_NOTFOUND;
      end
      default: st_d = plist_pkg::ST_RANGE;
    endcase
  end

  always_comb begin
    stat_o.kind    = kind_q;
    stat_o.refused = (st_q == plist_pkg::ST_RANGE) || (st_q == plist_pkg::ST_FULL);
    stat_o.match   = (rdata_q == val_q);
    stat_o.empty   = 1'b0;
    stat_o.last    = 1'b1;
    unique case (kind_q)
      plist_pkg::KIND_INSERT: begin
        stat_o.empty = cnt_x < pos_x;
        stat_o.last  = idx_x <= pos_x;
      end
      plist_pkg::KIND_REMOVE: stat_o.last = idx_x + XW'(1) >= cnt_x;
      plist_pkg::KIND_READ:   stat_o.last = 1'b1;
      plist_pkg::KIND_FIND: begin
        stat_o.empty = count_q == '0;
        stat_o.last  = idx_x + XW'(1) >= cnt_x;
      end
      default: stat_o.last = 1'b1;
    endcase
  end

  always_comb begin
    rd_idx  = (kind_q == plist_pkg::KIND_INSERT) ? idx_q - CW'(1) : idx_q;
    wr_en   = 1'b0;
    wr_idx  = idx_q;
    wr_data = rdata_q;
    if (cmd_i.put) begin
      wr_en   = 1'b1;
      wr_idx  = CW'(pos_x - XW'(1));
      wr_data = val_q;
    end else if (cmd_i.wr && kind_q == plist_pkg::KIND_INSERT) begin
      wr_en = 1'b1;
    end else if (cmd_i.wr && kind_q == plist_pkg::KIND_REMOVE &&
                 idx_x != pos_x - XW'(1)) begin
      wr_en  = 1'b1;
      wr_idx = idx_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_idx[AW-1:0]] <= wr_data;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem[rd_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= plist_pkg::kind_e'(kind_i);
      pos_q   <= pos_i;
      val_q   <= val_i;
      idx_q   <= idx_init;
      st_q    <= st_d;
      vout_q  <= '0;
      found_q <= '0;
    end else if (cmd_i.wr) begin
      unique case (kind_q)
        plist_pkg::KIND_INSERT: idx_q <= idx_q - CW'(1);
        plist_pkg::KIND_REMOVE: begin
          if (idx_x == pos_x - XW'(1)) begin
            vout_q <= rdata_q;
          end
          idx_q <= idx_q + CW'(1);
        end
        plist_pkg::KIND_READ: vout_q <= rdata_q;
        plist_pkg::KIND_FIND: begin
          if (rdata_q == val_q) begin
            found_q <= idx_x + XW'(1);
            st_q    <= plist_pkg::ST_OK;
          end else begin
            idx_q <= idx_q + CW'(1);
          end
        end
        default: idx_q <= idx_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.put) begin
      count_q <= count_q + CW'(1);
    end else if (cmd_i.wr && kind_q == plist_pkg::KIND_REMOVE && stat_o.last) begin
      count_q <= count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      o_status_q <= st_q;
      o_value_q  <= vout_q;
      o_found_q  <= found_q[plist_pkg::LenW-1:0];
      o_len_q    <= cnt_x[plist_pkg::LenW-1:0];
    end
  end

  assign out_busy_o  = out_valid_q && !out_ready_i;
  assign out_valid_o = out_valid_q;
  assign status_o    = o_status_q;
  assign value_out_o = o_value_q;
  assign found_o     = o_found_q;
  assign len_o       = o_len_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_x <= XW'(DEPTH))
    else $error("count above depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> !out_valid_q)
    else $error("result register overwritten");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == $past(count_q) || count_q == $past(count_q) + CW'(1) ||
    count_q == $past(count_q) - CW'(1))
    else $error("count stepped by more than one");

endmodule

FILE: rtl/positional_list_engine.sv
// Top level: ordered list engine with stream request and result channels.
// A read fetches one entry; a refused request skips the memory; a find scans entries
// until a match; insert shifts entries up; remove shifts entries from position to end.
// Throughput: one request in flight; the next transfer is taken once the result is
// registered and the output is free; the single-port list memory sweep sets the rate.
// Reset: asynchronous, active low; empties the list; memory contents are kept.
`timescale 1ns / 1ps
module positional_list_engine #(
  parameter int unsigned DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // position[6:0], value[38:7], zero pad
  input  logic [1:0]  s_axis_tuser,  // kind[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // status, value_out, found_position, list_length
);

  plist_pkg::cmd_t  cmd;
  plist_pkg::stat_t stat;
  logic             out_busy;
  logic [1:0]       status;
  logic [31:0]      value_out;
  logic [6:0]       found_position, list_length;

  plist_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .out_busy_i (out_busy),
    .stat_i     (stat),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  plist_dp #(.DEPTH(DEPTH)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .kind_i      (s_axis_tuser),
    .pos_i       (s_axis_tdata[6:0]),
    .val_i       (s_axis_tdata[38:7]),
    .out_ready_i (m_axis_tready),
    .out_busy_o  (out_busy),
    .out_valid_o (m_axis_tvalid),
    .status_o    (status),
    .value_out_o (value_out),
    .found_o     (found_position),
    .len_o       (list_length)
  );

  assign m_axis_tdata = {list_length, found_position, value_out, status};

endmodule

FILE: tb/tb_positional_list_engine.sv
// Testbench: directed and randomized list requests checked against an in-bench list model.
`timescale 1ns / 1ps
module tb_positional_list_engine;

  localparam int unsigned Depth = 64;
  localparam int unsigned PosW  = plist_pkg::PosW;
  localparam int unsigned ValW  = plist_pkg::ValW;
  localparam int unsigned LenW  = plist_pkg::LenW;

  typedef struct packed {
    plist_pkg::kind_e kind;
    logic [PosW-1:0]  position;
    logic [ValW-1:0]  value;
  } request_t;

  typedef struct packed {
    logic [LenW-1:0]    list_length;
    logic [PosW-1:0]    found_position;
    logic [ValW-1:0]    value_out;
    plist_pkg::status_e status;
  } answer_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;

  positional_list_engine #(.DEPTH(Depth)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  request_t        pending_q[$];
  answer_t         answer_q[$];
  logic [ValW-1:0] list_mem[Depth];
  int unsigned     list_len;
  int unsigned     model_len;
  int              send_idle_pct;
  int              recv_stall_pct;
  int              hold_cycles;
  bit              hold_req;
  bit              hold_taken;
  int              errors;
  int              accepted;
  int              checked;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

  function automatic answer_t list_apply(request_t r);
    answer_t a;
    int unsigned p;
    a = '0;
    a.status = plist_pkg::ST_OK;
    p = r.position;
    case (r.kind)
      plist_pkg::KIND_INSERT: begin
        if (p < 1 || p > list_len + 1) a.status = plist_pkg::ST_RANGE;
        else if (list_len >= Depth) a.status = plist_pkg::ST_FULL;
        else begin
          for (int k = list_len; k >= p; k--) list_mem[k] = list_mem[k-1];
          list_mem[p-1] = r.value;
          list_len++;
        end
      end
      plist_pkg::KIND_REMOVE: begin
        if (p < 1 || p > list_len) a.status = plist_pkg::ST_RANGE;
        else begin
          a.value_out = list_mem[p-1];
          for (int k = p; k < list_len; k++) list_mem[k-1] = list_mem[k];
          list_len--;
        end
      end
      plist_pkg::KIND_READ: begin
        if (p < 1 || p > list_len) a.status = plist_pkg::ST_RANGE;
        else a.value_out = list_mem[p-1];
      end
      default: begin
        a.status = plist_pkg::ST_NOTFOUND;
        for (int k = 0; k < list_len; k++) begin
          if (list_mem[k] == r.value) begin
            a.status = plist_pkg::ST_OK;
            a.found_position = PosW'(k + 1);
            break;
          end
        end
      end
    endcase
    a.list_length = LenW'(list_len);
    return a;
  endfunction

  // Keeps a shadow length so generated positions aim near the valid range.
  function automatic void queue_req(plist_pkg::kind_e k, int unsigned p, logic [31:0] v);
    request_t r;
    r.kind = k;
    r.position = PosW'(p);
    r.value = v;
    pending_q.push_back(r);
    case (k)
      plist_pkg::KIND_INSERT:
        if (p >= 1 && p <= model_len + 1 && model_len < Depth) model_len++;
      plist_pkg::KIND_REMOVE: if (p >= 1 && p <= model_len) model_len--;
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  function automatic void random_req();
    int unsigned sel;
    int unsigned p;
    sel = $urandom_range(0, 99);
    if (sel < 5) p = $urandom_range(0, 127);
    else if (sel < 10) p = model_len + 1 + $urandom_range(0, 1);
    else p = $urandom_range(1, model_len + 1);
    sel = $urandom_range(0, 99);
    if (model_len > 48 && sel < 45) sel = 40;
    if (sel < 40) queue_req(plist_pkg::KIND_INSERT, p, rand_value());
    else if (sel < 60) queue_req(plist_pkg::KIND_REMOVE, p, 0);
    else if (sel < 80) queue_req(plist_pkg::KIND_READ, p, $urandom);
    else queue_req(plist_pkg::KIND_FIND, 0, rand_value());
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        request_t r;
        r = pending_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, r.value, r.position};
        s_axis_tuser  <= r.kind;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_cycles   <= 0;
      hold_taken    <= 1'b0;
    end else if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles   <= hold_cycles - 1;
    end else if (hold_req && !hold_taken) begin
      m_axis_tready <= 1'b0;
      hold_cycles   <= 400;
      hold_taken    <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      request_t r;
      r.kind = plist_pkg::kind_e'(s_axis_tuser);
      r.position = s_axis_tdata[6:0];
      r.value = s_axis_tdata[38:7];
      answer_q.push_back(list_apply(r));
      accepted++;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      answer_t got;
      answer_t want;
      got = m_axis_tdata;
      if (answer_q.size() == 0) begin
        $display("%0t: unexpected transfer %h", $realtime, m_axis_tdata);
        errors++;
      end else begin
        want = answer_q.pop_front();
        checked++;
        if (got.status != want.status) begin
          $display("%0t: status exp %0d got %0d", $realtime, want.status, got.status);
          errors++;
        end
        if (got.value_out != want.value_out) begin
          $display("%0t: value_out exp %h got %h", $realtime, want.value_out, got.value_out);
          errors++;
        end
        if (got.found_position != want.found_position) begin
          $display("%0t: found_position exp %0d got %0d", $realtime,
                   want.found_position, got.found_position);
          errors++;
        end
        if (got.list_length != want.list_length) begin
          $display("%0t: list_length exp %0d got %0d", $realtime,
                   want.list_length, got.list_length);
          errors++;
        end
      end
    end
  end

  task automatic drain();
    int guard;
    guard = 0;
    while ((pending_q.size() != 0 || s_axis_tvalid || answer_q.size() != 0)
           && guard < 2000000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (300) @(posedge clk_i);
  endtask

  initial begin
    rst_ni = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b0;
    model_len = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_req(plist_pkg::KIND_READ, 1, 0);
    queue_req(plist_pkg::KIND_REMOVE, 1, 0);
    queue_req(plist_pkg::KIND_FIND, 0, 32'h0);
    queue_req(plist_pkg::KIND_INSERT, 0, 32'h5);
    queue_req(plist_pkg::KIND_INSERT, 2, 32'h5);
    queue_req(plist_pkg::KIND_INSERT, 1, 32'h8000_0000);
    queue_req(plist_pkg::KIND_INSERT, 2, 32'h7FFF_FFFF);
    queue_req(plist_pkg::KIND_INSERT, 1, 32'hFFFF_FFFF);
    queue_req(plist_pkg::KIND_INSERT, 4, 32'h7FFF_FFFF);
    queue_req(plist_pkg::KIND_FIND, 0, 32'h7FFF_FFFF);
    queue_req(plist_pkg::KIND_FIND, 0, 32'h1234_5678);
    queue_req(plist_pkg::KIND_READ, 4, 0);
    queue_req(plist_pkg::KIND_READ, 5, 0);
    queue_req(plist_pkg::KIND_READ, 127, 32'hFFFF_FFFF);
    queue_req(plist_pkg::KIND_REMOVE, 2, 0);
    queue_req(plist_pkg::KIND_REMOVE, 0, 0);
    queue_req(plist_pkg::KIND_INSERT, 127, 32'hAAAA_5555);
    for (int i = 0; i < 62; i++) queue_req(plist_pkg::KIND_INSERT, model_len + 1, $urandom);
    queue_req(plist_pkg::KIND_INSERT, 1, 32'h1);
    queue_req(plist_pkg::KIND_INSERT, 66, 32'h1);
    queue_req(plist_pkg::KIND_FIND, 0, 32'h7FFF_FFFF);
    queue_req(plist_pkg::KIND_READ, 64, 0);
    queue_req(plist_pkg::KIND_REMOVE, 64, 0);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        3: begin send_idle_pct = 23; recv_stall_pct = 23; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; hold_req = 1'b1; end
      endcase
      for (int i = 0; i < 180; i++) random_req();
      drain();
    end

    if (answer_q.size() != 0 || checked != accepted) begin
      $display("%0t: results outstanding exp %0d got %0d", $realtime, accepted, checked);
    end
    $display("Checked %0d of %0d requests: all kinds, range and full refusals,", checked,
             accepted);
    $display("extreme values, duplicates, idle and stall phases, long output hold-off.");
    if (errors == 0 && answer_q.size() == 0 && checked == accepted) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
